### rtl/sh64_pkg.sv
// sh64_pkg: constants, command types and helpers for the streaming 64-bit hash engine.
// No dependencies.
`timescale 1ns / 1ps
package sh64_pkg;

  localparam logic [63:0] PR1 = 64'd11400714785074694791;
  localparam logic [63:0] PR2 = 64'd14029467366897019727;
  localparam logic [63:0] PR3 = 64'd1609587929392839161;
  localparam logic [63:0] PR4 = 64'd9650029242287828579;
  localparam logic [63:0] PR5 = 64'd2870177450012600261;

  localparam logic [63:0] LANE0_INIT = PR1 + PR2;
  localparam logic [63:0] LANE1_INIT = PR2;
  localparam logic [63:0] LANE2_INIT = 64'd0;
  localparam logic [63:0] LANE3_INIT = 64'd0 - PR1;

  // multiplier operand select
  typedef enum logic [1:0] {
    MC_P1 = 2'd0,
    MC_P2 = 2'd1,
    MC_P3 = 2'd2,
    MC_P5 = 2'd3
  } mconst_t;

  // datapath micro-operations, one per controller step
  typedef enum logic [4:0] {
    OP_NOP,
    OP_STORE,      // store word in stripe buffer
    OP_LR_MUL1,    // t = w * P2 (w = stripe[k] or the incoming word)
    OP_LR_ADD,     // t = rotl(acc[k] + t, 31) * P1 -> acc[k]
    OP_MG_INIT,    // h = rotl sum of lanes
    OP_MG_MUL1,    // t = lane[k] * P2
    OP_MG_MUL2,    // t = rotl(t,31) * P1
    OP_MG_MUL3,    // h = (h ^ t) * P1 + P4
    OP_SH_INIT,    // h = P5
    OP_ADD_LEN,    // h += len
    OP_TW_MUL1,    // t = tailword * P2
    OP_TW_MUL2,    // t = rotl(t,31) * P1
    OP_TW_MUL3,    // h = rotl(h ^ t, 27) * P1 + P4
    OP_T4_MUL1,    // t = rest[31:0] * P1
    OP_T4_MUL2,    // h = rotl(h ^ t, 23) * P2 + P3; rest >>= 32
    OP_T1_MUL1,    // t = rest[7:0] * P5
    OP_T1_MUL2,    // h = rotl(h ^ t, 11) * P1; rest >>= 8
    OP_AV_MUL1,    // h = (h ^ h>>33) * P2
    OP_AV_MUL2,    // h = (h ^ h>>29) * P3
    OP_AV_FIN,     // hash = h ^ h>>32
    OP_RESET       // lanes, fill, length back to initial values
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] idx;      // lane or stripe index
    logic       use_word; // operand is incoming word instead of stripe entry
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] fill;
    logic       long_path;  // length >= 32 after this word
    logic       mul_done;
  } dp_stat_t;

  function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned r);
    rotl64 = (v << r) | (v >> (64 - r));
  endfunction

endpackage

### rtl/sh64_mul.sv
// sh64_mul: 64x64 low-half multiplier built from three 32x32 partial products over stages.
// Depends on sh64_pkg.
`timescale 1ns / 1ps
module sh64_mul
  import sh64_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] p
);
  logic [63:0] ll_r;
  logic [31:0] lh_r, hl_r;
  logic [1:0]  vld_r;
  logic [63:0] p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 2'b00;
    end else begin
      vld_r <= {vld_r[0], start};
    end
    ll_r <= 64'(a[31:0]) * 64'(b[31:0]);
    lh_r <= 32'(a[31:0] * b[63:32]);
    hl_r <= 32'(a[63:32] * b[31:0]);
    p_r  <= ll_r + {lh_r + hl_r, 32'd0};
  end

  assign done = vld_r[1];
  assign p    = p_r;
endmodule

### rtl/sh64_datapath.sv
// sh64_datapath: lane accumulators, stripe buffer, length, hash register, shared multiplier.
// Depends on sh64_pkg and sh64_mul.
`timescale 1ns / 1ps
module sh64_datapath
  import sh64_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,       // capture incoming item
  input  logic [63:0] in_word,
  input  logic [3:0]  in_bytes,
  input  logic        in_last,
  input  logic        mul_go,     // first cycle of a multiply step
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  output logic [63:0] hash
);
  logic [63:0] lane_r [4];
  logic [63:0] stripe_r [3];
  logic [1:0]  fill_r;
  logic [63:0] len_r;
  logic [63:0] word_r, rest_r, h_r, t_r;
  logic [63:0] ma, mb, mp;
  logic        mstart, mdone;
  logic [63:0] opnd, x;
  logic [63:0] add8;

  assign opnd = cmd.use_word ? word_r : stripe_r[cmd.idx];
  assign add8 = !in_last ? 64'd8 : (in_bytes > 4'd8 ? 64'd8 : 64'(in_bytes));

  always_comb begin
    ma = 64'd0;
    mb = PR1;
    mstart = mul_go;
    x = 64'd0;
    case (cmd.op)
      OP_LR_MUL1: begin ma = opnd; mb = PR2; end
      OP_LR_ADD:  begin ma = rotl64(lane_r[cmd.idx] + t_r, 31); end
      OP_MG_MUL1: begin ma = lane_r[cmd.idx]; mb = PR2; end
      OP_MG_MUL2, OP_TW_MUL2: begin ma = rotl64(t_r, 31); end
      OP_MG_MUL3: begin ma = h_r ^ t_r; end
      OP_TW_MUL1: begin ma = opnd; mb = PR2; end
      OP_TW_MUL3: begin ma = rotl64(h_r ^ t_r, 27); end
      OP_T4_MUL1: begin ma = {32'd0, rest_r[31:0]}; end
      OP_T4_MUL2: begin ma = rotl64(h_r ^ t_r, 23); mb = PR2; end
      OP_T1_MUL1: begin ma = {56'd0, rest_r[7:0]}; mb = PR5; end
      OP_T1_MUL2: begin ma = rotl64(h_r ^ t_r, 11); end
      OP_AV_MUL1: begin ma = h_r ^ (h_r >> 33); mb = PR2; end
      OP_AV_MUL2: begin ma = h_r ^ (h_r >> 29); mb = PR3; end
      default: begin mstart = 1'b0; x = 64'd0; end
    endcase
  end

  sh64_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mstart), .a(ma), .b(mb), .done(mdone), .p(mp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r[0] <= LANE0_INIT;
      lane_r[1] <= LANE1_INIT;
      lane_r[2] <= LANE2_INIT;
      lane_r[3] <= LANE3_INIT;
      fill_r    <= 2'd0;
      len_r     <= 64'd0;
    end else begin
      if (load) begin
        len_r <= len_r + add8;
      end
      if (mdone) begin
        case (cmd.op)
          OP_LR_MUL1, OP_MG_MUL1, OP_MG_MUL2, OP_TW_MUL1, OP_TW_MUL2,
          OP_T4_MUL1, OP_T1_MUL1: t_r <= mp;
          OP_LR_ADD: begin
            lane_r[cmd.idx] <= mp;
            if (cmd.idx == 2'd3) fill_r <= 2'd0;
          end
          OP_MG_MUL3, OP_TW_MUL3: h_r <= mp + PR4;
          OP_T4_MUL2: begin h_r <= mp + PR3; rest_r <= rest_r >> 32; end
          OP_T1_MUL2: begin h_r <= mp; rest_r <= rest_r >> 8; end
          OP_AV_MUL1, OP_AV_MUL2: h_r <= mp;
          default: ;
        endcase
      end
      case (cmd.op)
        OP_STORE: begin
          stripe_r[fill_r] <= word_r;
          fill_r <= fill_r + 2'd1;
        end
        OP_MG_INIT: h_r <= rotl64(lane_r[0], 1) + rotl64(lane_r[1], 7) +
                           rotl64(lane_r[2], 12) + rotl64(lane_r[3], 18);
        OP_SH_INIT: h_r <= PR5;
        OP_ADD_LEN: h_r <= h_r + len_r + x;
        OP_AV_FIN:  h_r <= h_r ^ (h_r >> 32);
        OP_RESET: begin
          lane_r[0] <= LANE0_INIT;
          lane_r[1] <= LANE1_INIT;
          lane_r[2] <= LANE2_INIT;
          lane_r[3] <= LANE3_INIT;
          fill_r    <= 2'd0;
          len_r     <= 64'd0;
        end
        default: ;
      endcase
    end
    if (load) begin
      word_r <= in_word;
      rest_r <= in_word;
    end
  end

  assign stat.fill      = fill_r;
  assign stat.long_path = (len_r >= 64'd32);
  assign stat.mul_done  = mdone;
  assign hash           = h_r;
endmodule

### rtl/sh64_ctrl.sv
// sh64_ctrl: sequencer that issues datapath operations for each accepted word.
// Depends on sh64_pkg.
`timescale 1ns / 1ps
module sh64_ctrl
  import sh64_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic [3:0] in_bytes,
  input  logic     in_last,
  output logic     in_stall,
  output logic     load,
  output dp_cmd_t  cmd,
  output logic     mul_go,
  input  dp_stat_t stat,
  output logic     res_valid,
  input  logic     res_taken
);
  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_LR1, S_LR2, S_FIN_START, S_MG1, S_MG2, S_MG3,
    S_LEN, S_TW1, S_TW2, S_TW3, S_T4A, S_T4B, S_T1A, S_T1B
  } state_t;
  typedef enum logic [1:0] { A_IDLE, A_M1, A_M2, A_FIN } av_t;

  state_t     state_r;
  av_t        av_r;
  logic       issued_r;   // multiplier op in flight for current step
  logic       last_r, full_r;
  logic [3:0] nb_r;       // saturated byte count of last word
  logic [1:0] k_r;        // lane / tail index
  logic [2:0] ntw_r;      // tail words pending incl. word
  logic       res_r;
  logic       busy;
  logic       step_go;    // multiplier step completes this cycle

  assign busy      = (state_r != S_IDLE) || (av_r != A_IDLE) || res_r;
  assign in_stall  = busy;
  assign load      = in_valid && !busy;
  assign res_valid = res_r;
  assign step_go   = issued_r && stat.mul_done;
  // multiplier is started once per step, in its first cycle
  assign mul_go    = !issued_r;

  always_comb begin
    cmd = '{op: OP_NOP, idx: k_r, use_word: 1'b0};
    unique case (state_r)
      S_LR1:  cmd = '{op: OP_LR_MUL1, idx: k_r, use_word: (k_r == 2'd3)};
      S_LR2:  cmd = '{op: OP_LR_ADD,  idx: k_r, use_word: 1'b0};
      S_MG1:  cmd.op = OP_MG_MUL1;
      S_MG2:  cmd.op = OP_MG_MUL2;
      S_MG3:  cmd.op = OP_MG_MUL3;
      S_TW1:  cmd = '{op: OP_TW_MUL1, idx: k_r, use_word: (k_r == stat.fill)};
      S_TW2:  cmd.op = OP_TW_MUL2;
      S_TW3:  cmd.op = OP_TW_MUL3;
      S_T4A:  cmd.op = OP_T4_MUL1;
      S_T4B:  cmd.op = OP_T4_MUL2;
      S_T1A:  cmd.op = OP_T1_MUL1;
      S_T1B:  cmd.op = OP_T1_MUL2;
      default: ;
    endcase
    // one-shot ops and the avalanche are issued only when no step is running
    if (state_r == S_DISPATCH && !last_r && !full_r) cmd.op = OP_STORE;
    if (state_r == S_FIN_START) cmd.op = stat.long_path ? OP_MG_INIT : OP_SH_INIT;
    if (state_r == S_LEN) cmd.op = OP_ADD_LEN;
    if (state_r == S_IDLE) begin
      unique case (av_r)
        A_M1:   cmd.op = OP_AV_MUL1;
        A_M2:   cmd.op = OP_AV_MUL2;
        A_FIN:  cmd.op = OP_AV_FIN;
        // while the hash waits, put lanes, fill and length back to start
        default: if (res_r) cmd.op = OP_RESET;
      endcase
    end
    // start the multiplier only in the issuing cycle;
    // afterwards keep it so the result lands with the right op
  end

  // multiplier ops: cmd holds from issue through the 2 multiplier stages; issued_r marks waiting
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      av_r     <= A_IDLE;
      issued_r <= 1'b0;
      res_r    <= 1'b0;
      k_r      <= 2'd0;
    end else begin
      if (res_r && res_taken) res_r <= 1'b0;
      if (issued_r && !stat.mul_done) begin
        // waiting
      end
      unique case (state_r)
        S_IDLE: begin
          if (av_r != A_IDLE) begin
            unique case (av_r)
              A_M1: if (step_go) begin av_r <= A_M2; issued_r <= 1'b0; end
                    else issued_r <= 1'b1;
              A_M2: if (step_go) begin av_r <= A_FIN; issued_r <= 1'b0; end
                    else issued_r <= 1'b1;
              A_FIN: begin av_r <= A_IDLE; res_r <= 1'b1; end
              default: ;
            endcase
          end else if (load) begin
            state_r <= S_DISPATCH;
            last_r  <= in_last;
            nb_r    <= (in_bytes > 4'd8) ? 4'd8 : in_bytes;
            full_r  <= (!in_last || in_bytes >= 4'd8) && (stat.fill == 2'd3);
          end
        end
        S_DISPATCH: begin
          k_r <= 2'd0;
          if (full_r) state_r <= S_LR1;
          else if (last_r) state_r <= S_FIN_START;
          else state_r <= S_IDLE;
        end
        S_LR1: if (step_go) begin state_r <= S_LR2; issued_r <= 1'b0; end
               else issued_r <= 1'b1;
        S_LR2: if (step_go) begin
                 issued_r <= 1'b0;
                 k_r <= k_r + 2'd1;
                 if (k_r != 2'd3) state_r <= S_LR1;
                 else if (last_r) state_r <= S_FIN_START;
                 else state_r <= S_IDLE;
               end else issued_r <= 1'b1;
        S_FIN_START: begin
          k_r <= 2'd0;
          // tail words: buffered entries, plus the word if it is full and unconsumed
          ntw_r <= full_r ? 3'd0 : (3'(stat.fill) + ((nb_r == 4'd8) ? 3'd1 : 3'd0));
          if (full_r) nb_r <= 4'd0;
          else if (nb_r == 4'd8) nb_r <= 4'd0;
          state_r <= stat.long_path ? S_MG1 : S_LEN;
        end
        S_MG1: if (step_go) begin state_r <= S_MG2; issued_r <= 1'b0; end
               else issued_r <= 1'b1;
        S_MG2: if (step_go) begin state_r <= S_MG3; issued_r <= 1'b0; end
               else issued_r <= 1'b1;
        S_MG3: if (step_go) begin
                 issued_r <= 1'b0;
                 k_r <= k_r + 2'd1;
                 state_r <= (k_r == 2'd3) ? S_LEN : S_MG1;
               end else issued_r <= 1'b1;
        S_LEN: begin
          k_r <= 2'd0;
          if (ntw_r != 3'd0) state_r <= S_TW1;
          else if (nb_r >= 4'd4) state_r <= S_T4A;
          else if (nb_r != 4'd0) state_r <= S_T1A;
          else begin state_r <= S_IDLE; av_r <= A_M1; end
        end
        S_TW1: if (step_go) begin state_r <= S_TW2; issued_r <= 1'b0; end
               else issued_r <= 1'b1;
        S_TW2: if (step_go) begin state_r <= S_TW3; issued_r <= 1'b0; end
               else issued_r <= 1'b1;
        S_TW3: if (step_go) begin
                 issued_r <= 1'b0;
                 k_r  <= k_r + 2'd1;
                 ntw_r <= ntw_r - 3'd1;
                 if (ntw_r != 3'd1) state_r <= S_TW1;
                 else if (nb_r >= 4'd4) state_r <= S_T4A;
                 else if (nb_r != 4'd0) state_r <= S_T1A;
                 else begin state_r <= S_IDLE; av_r <= A_M1; end
               end else issued_r <= 1'b1;
        S_T4A: if (step_go) begin state_r <= S_T4B; issued_r <= 1'b0; end
               else issued_r <= 1'b1;
        S_T4B: if (step_go) begin
                 issued_r <= 1'b0;
                 nb_r <= nb_r - 4'd4;
                 if (nb_r != 4'd4) state_r <= S_T1A;
                 else begin state_r <= S_IDLE; av_r <= A_M1; end
               end else issued_r <= 1'b1;
        S_T1A: if (step_go) begin state_r <= S_T1B; issued_r <= 1'b0; end
               else issued_r <= 1'b1;
        S_T1B: if (step_go) begin
                 issued_r <= 1'b0;
                 nb_r <= nb_r - 4'd1;
                 if (nb_r != 4'd1) state_r <= S_T1A;
                 else begin state_r <= S_IDLE; av_r <= A_M1; end
               end else issued_r <= 1'b1;
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !load) else $error("item taken while busy");
  a_res_holds: assert property (@(posedge clk) disable iff (!rst_n)
    res_r && !res_taken |=> res_r) else $error("result dropped");
  a_av_after_tail: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(res_r) |-> $past(av_r) == A_FIN) else $error("result without avalanche");
`endif
endmodule

### rtl/streaming_hash64_engine_top.sv
// streaming_hash64_engine_top: top level of the streaming 64-bit hash engine.
// Depends on sh64_pkg, sh64_ctrl, sh64_datapath, sh64_mul.
`timescale 1ns / 1ps
// Computes the seed-0 XXH64 hash of a message fed as little-endian 64-bit
// items (first byte in bits 7:0). in_bytes_valid counts valid low bytes and
// may be below 8 only on the item with in_last_word set; that item yields one
// out_hash_value. One item is taken at a time. Every multiply runs through one
// shared 64x64 multiplier built from 32x32 partial products, which sets the
// timing: a plain item is only stored, an item that completes a 32-byte
// stripe runs four lane rounds of two multiplies, and the last item adds the
// merge (when the length reaches 32 bytes), tail words, a four-byte tail
// chunk, tail bytes and the avalanche. The result sits in an output register
// until taken; the next item is accepted once it has gone.
module streaming_hash64_engine_top
  import sh64_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_message_word,
  input  logic [3:0]  in_bytes_valid,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_hash_value
);
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     load;
  logic     mul_go;

  sh64_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_bytes(in_bytes_valid),
    .in_last(in_last_word), .in_stall(in_stall), .load(load), .cmd(cmd),
    .mul_go(mul_go), .stat(stat), .res_valid(out_valid), .res_taken(!out_stall)
  );

  sh64_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .load(load), .in_word(in_message_word),
    .in_bytes(in_bytes_valid), .in_last(in_last_word), .mul_go(mul_go), .cmd(cmd),
    .stat(stat), .hash(out_hash_value)
  );
endmodule
